// ----- hdl/pnd_pkg.sv -----
package pnd_pkg;

  // Build constants
  localparam int OCTAVE_COUNT     = 8;
  localparam int COUNT_BITS       = 24;
  localparam int RING_DEPTH       = 5;
  localparam int HARMONIC_COUNT   = 4;
  localparam int NOTES_PER_OCTAVE = 12;
  localparam int TABLE_SIZE       = 96;

  localparam int NOTE_LIMIT = (NOTES_PER_OCTAVE * OCTAVE_COUNT > TABLE_SIZE) ?
                              TABLE_SIZE : NOTES_PER_OCTAVE * OCTAVE_COUNT;

  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int HARM_W = $clog2(HARMONIC_COUNT);
  localparam int IDX_W  = 7;
  localparam int OCT_W  = 4;
  localparam int SUM_W  = COUNT_BITS + 3;
  localparam int NOTE_W = 21;
  localparam int DIST_W = (SUM_W > NOTE_W) ? SUM_W : NOTE_W;
  localparam int PSUM_W = 26;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int TOL_W      = 4;

  localparam logic [TOL_W-1:0] TOL_RESET = 4'd7;
  // Word select bit of the byte address, register 0 is the tolerance shift
  localparam logic REG_TOL_SHIFT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ACC,
    ST_CHECK,
    ST_SEARCH,
    ST_EMIT
  } pnd_state_t;

  // Difference pattern expected for each harmonic
  function automatic logic [RING_DEPTH-1:0] match_mask(input logic [HARM_W-1:0] h);
    logic [RING_DEPTH-1:0] m;
    case (h)
      2'd0:    m = 5'b11111;
      2'd1:    m = 5'b10101;
      2'd2:    m = 5'b01001;
      2'd3:    m = 5'b10001;
      default: m = 5'b00000;
    endcase
    return m;
  endfunction

  // Note periods in clock ticks, C0 upwards
  function automatic logic [NOTE_W-1:0] note_period(input logic [IDX_W-1:0] idx);
    logic [NOTE_W-1:0] p;
    case (idx)
      7'd0:  p = 21'd1223122; 7'd1:  p = 21'd1154474; 7'd2:  p = 21'd1089678;
      7'd3:  p = 21'd1028519; 7'd4:  p = 21'd970793;  7'd5:  p = 21'd916306;
      7'd6:  p = 21'd864878;  7'd7:  p = 21'd816336;  7'd8:  p = 21'd770519;
      7'd9:  p = 21'd727273;  7'd10: p = 21'd686454;  7'd11: p = 21'd647926;
      7'd12: p = 21'd611561;  7'd13: p = 21'd577237;  7'd14: p = 21'd544839;
      7'd15: p = 21'd514260;  7'd16: p = 21'd485396;  7'd17: p = 21'd458153;
      7'd18: p = 21'd432439;  7'd19: p = 21'd408168;  7'd20: p = 21'd385259;
      7'd21: p = 21'd363636;  7'd22: p = 21'd343227;  7'd23: p = 21'd323963;
      7'd24: p = 21'd305781;  7'd25: p = 21'd288618;  7'd26: p = 21'd272419;
      7'd27: p = 21'd257130;  7'd28: p = 21'd242698;  7'd29: p = 21'd229077;
      7'd30: p = 21'd216219;  7'd31: p = 21'd204084;  7'd32: p = 21'd192630;
      7'd33: p = 21'd181818;  7'd34: p = 21'd171614;  7'd35: p = 21'd161982;
      7'd36: p = 21'd152890;  7'd37: p = 21'd144309;  7'd38: p = 21'd136210;
      7'd39: p = 21'd128565;  7'd40: p = 21'd121349;  7'd41: p = 21'd114538;
      7'd42: p = 21'd108110;  7'd43: p = 21'd102042;  7'd44: p = 21'd96315;
      7'd45: p = 21'd90909;   7'd46: p = 21'd85807;   7'd47: p = 21'd80991;
      7'd48: p = 21'd76445;   7'd49: p = 21'd72155;   7'd50: p = 21'd68105;
      7'd51: p = 21'd64282;   7'd52: p = 21'd60675;   7'd53: p = 21'd57269;
      7'd54: p = 21'd54055;   7'd55: p = 21'd51021;   7'd56: p = 21'd48157;
      7'd57: p = 21'd45455;   7'd58: p = 21'd42903;   7'd59: p = 21'd40495;
      7'd60: p = 21'd38223;   7'd61: p = 21'd36077;   7'd62: p = 21'd34052;
      7'd63: p = 21'd32141;   7'd64: p = 21'd30337;   7'd65: p = 21'd28635;
      7'd66: p = 21'd27027;   7'd67: p = 21'd25511;   7'd68: p = 21'd24079;
      7'd69: p = 21'd22727;   7'd70: p = 21'd21452;   7'd71: p = 21'd20248;
      7'd72: p = 21'd19111;   7'd73: p = 21'd18039;   7'd74: p = 21'd17026;
      7'd75: p = 21'd16071;   7'd76: p = 21'd15169;   7'd77: p = 21'd14317;
      7'd78: p = 21'd13514;   7'd79: p = 21'd12755;   7'd80: p = 21'd12039;
      7'd81: p = 21'd11364;   7'd82: p = 21'd10726;   7'd83: p = 21'd10124;
      7'd84: p = 21'd9556;    7'd85: p = 21'd9019;    7'd86: p = 21'd8513;
      7'd87: p = 21'd8035;    7'd88: p = 21'd7584;    7'd89: p = 21'd7159;
      7'd90: p = 21'd6757;    7'd91: p = 21'd6378;    7'd92: p = 21'd6020;
      7'd93: p = 21'd5682;    7'd94: p = 21'd5363;    7'd95: p = 21'd5062;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

// ----- hdl/period_note_detector.sv -----
// Sequence: an accepted count reads the five-entry history one slot at a time, checks up to
//   4 harmonic patterns in turn, then scans the note table (NOTE_LIMIT entries, one entry
//   per cycle); out_tvalid rises once the result is loaded into the free output register.
// Throughput: one count at a time; the next count is taken once the block is back in idle,
//   after the table scan of a matching one or the last pattern check of one with no match,
//   later while a result waits in the output register. Pace set by the table scan.
// Reset (synchronous, rst_n low): history valid bits and pointer cleared, so the ring
//   reads as all zero; tolerance shift returns to 7; no result pending.
module period_note_detector (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: [23:0] capture_count
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [pnd_pkg::IN_DATA_W-1:0]  in_tdata,
  // out_tdata: [25:0] period_sum, [32:26] note_index, [36:33] note_in_octave,
  //            [38:37] harmonic_found, [39] zero
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [pnd_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [pnd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [pnd_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [pnd_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import pnd_pkg::*;

  pnd_state_t state_r, state_nxt;

  // History memory with per-entry valid bits
  logic [COUNT_BITS-1:0] hist_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] hist_vld_r;
  logic [COUNT_BITS-1:0] mem_q_r;
  logic                  mem_q_vld_r;
  logic [SLOT_W-1:0]     ptr_r;
  logic [SLOT_W-1:0]     rd_slot_r;

  logic [TOL_W-1:0]      tol_shift_r;
  logic [COUNT_BITS-1:0] newest_r;
  logic [SUM_W-1:0]      acc_r;
  logic [SUM_W-1:0]      sums_r  [RING_DEPTH];
  logic [COUNT_BITS-1:0] diffs_r [RING_DEPTH];
  logic [SLOT_W-1:0]     a_cnt_r;
  logic [HARM_W-1:0]     h_cnt_r;

  logic [SUM_W-1:0]      period_r;
  logic [IDX_W-1:0]      idx_r;
  logic [OCT_W-1:0]      oct_r;
  logic [DIST_W-1:0]     best_dist_r;
  logic [IDX_W-1:0]      best_idx_r;
  logic [OCT_W-1:0]      best_oct_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                  in_xfer;
  logic                  cfg_wr;
  logic                  out_free;
  logic                  rd_en;
  logic [COUNT_BITS-1:0] cnt_in;
  logic [COUNT_BITS-1:0] rd_data;
  logic [SUM_W-1:0]      acc_nxt;
  logic [COUNT_BITS-1:0] diff_nxt;
  logic [SUM_W-1:0]      tol;
  logic [RING_DEPTH-1:0] pattern;
  logic                  pat_match;
  logic [DIST_W-1:0]     tbl_val;
  logic [DIST_W-1:0]     per_ext;
  logic [DIST_W-1:0]     tbl_gap;
  logic                  search_last;

  assign in_xfer  = in_tvalid & in_tready;
  assign cfg_wr   = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign out_free = ~out_valid_r | out_tready;
  assign cnt_in   = COUNT_BITS'(in_tdata);

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_TOL_SHIFT) ? CFG_DATA_W'(tol_shift_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_shift_r <= TOL_RESET;
    end else if (cfg_wr && cfg_paddr[2] == REG_TOL_SHIFT) begin
      tol_shift_r <= cfg_pwdata[TOL_W-1:0];
    end
  end

  // Memory write on transfer, registered read
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hist_mem[ptr_r] <= cnt_in;
    end
    if (rd_en) begin
      mem_q_r     <= hist_mem[rd_slot_r];
      mem_q_vld_r <= hist_vld_r[rd_slot_r];
    end
  end

  // Accumulate step: unwritten slots read as zero
  assign rd_data  = mem_q_vld_r ? mem_q_r : '0;
  assign acc_nxt  = acc_r + SUM_W'(rd_data);
  assign diff_nxt = (newest_r >= rd_data) ? newest_r - rd_data : rd_data - newest_r;

  // Harmonic pattern check
  assign tol = sums_r[SLOT_W'(h_cnt_r)] >> tol_shift_r;
  always_comb begin
    for (int d = 0; d < RING_DEPTH; d++) begin
      pattern[d] = SUM_W'(diffs_r[d]) <= tol;
    end
  end
  assign pat_match = (pattern == match_mask(h_cnt_r));

  // Table scan distance
  assign tbl_val     = DIST_W'(note_period(idx_r));
  assign per_ext     = DIST_W'(period_r);
  assign tbl_gap     = (per_ext >= tbl_val) ? per_ext - tbl_val : tbl_val - per_ext;
  assign search_last = (idx_r == IDX_W'(NOTE_LIMIT - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_xfer) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_ACC;
      ST_ACC: begin
        if (a_cnt_r == SLOT_W'(RING_DEPTH - 1)) state_nxt = ST_CHECK;
        else state_nxt = ST_READ;
      end
      ST_CHECK: begin
        if (pat_match) state_nxt = ST_SEARCH;
        else if (h_cnt_r == HARM_W'(HARMONIC_COUNT - 1)) state_nxt = ST_IDLE;
      end
      ST_SEARCH: if (search_last) state_nxt = ST_EMIT;
      ST_EMIT:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_READ: rd_en     = 1'b1;
      default: begin
        in_tready = 1'b0;
        rd_en     = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hist_vld_r  <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        hist_vld_r[ptr_r] <= 1'b1;
        ptr_r <= (ptr_r == SLOT_W'(RING_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
      end
      if (state_r == ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        newest_r  <= cnt_in;
        rd_slot_r <= ptr_r;
        acc_r     <= '0;
        a_cnt_r   <= '0;
        h_cnt_r   <= '0;
      end
      ST_ACC: begin
        acc_r            <= acc_nxt;
        sums_r[a_cnt_r]  <= acc_nxt;
        diffs_r[a_cnt_r] <= diff_nxt;
        a_cnt_r          <= a_cnt_r + 1'b1;
        rd_slot_r <= (rd_slot_r == '0) ? SLOT_W'(RING_DEPTH - 1) : rd_slot_r - 1'b1;
      end
      ST_CHECK: begin
        period_r <= sums_r[SLOT_W'(h_cnt_r)];
        idx_r    <= '0;
        oct_r    <= '0;
        if (!pat_match) h_cnt_r <= h_cnt_r + 1'b1;
      end
      ST_SEARCH: begin
        if (idx_r == '0 || tbl_gap < best_dist_r) begin
          best_dist_r <= tbl_gap;
          best_idx_r  <= idx_r;
          best_oct_r  <= oct_r;
        end
        idx_r <= idx_r + 1'b1;
        oct_r <= (oct_r == OCT_W'(NOTES_PER_OCTAVE - 1)) ? '0 : oct_r + 1'b1;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_data_r <= {1'b0, h_cnt_r, best_oct_r, best_idx_r, PSUM_W'(period_r)};
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks
  a_xfer_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == ST_READ)
    else $error("transfer did not start history read");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r < SLOT_W'(RING_DEPTH))
    else $error("history pointer out of range");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_free) |=> out_tvalid)
    else $error("result lost on emit");

  a_note_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[36:33] < OCT_W'(NOTES_PER_OCTAVE)) &&
                   (out_tdata[32:26] < IDX_W'(NOTE_LIMIT)))
    else $error("note fields out of range");

endmodule

// ----- tb/tb_period_note_detector.sv -----
module tb_period_note_detector;
  timeunit 1ns;
  timeprecision 1ps;

  // Register map and run constants
  localparam logic [pnd_pkg::CFG_ADDR_W-1:0] TOL_SHIFT_ADDR = '0;
  localparam logic [3:0] TOL_SHIFT_RESET = 4'd7;
  localparam int NOTE_COUNT    = 96;
  localparam int SETTLE_CYCLES = 150;   // a little over the table scan latency
  localparam int HOLD_CYCLES   = 3000;  // long receiver hold-off
  localparam int QUIET_LIMIT   = 20000; // cycles with no transfer before giving up
  localparam int PHASE_ITEMS   = 140;
  localparam int PHASES        = 8;

  // Idling modes of a phase
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // Note periods in clock ticks, C0 upwards
  localparam int NOTE_TICKS [NOTE_COUNT] = '{
    1223122, 1154474, 1089678, 1028519, 970793, 916306,
    864878, 816336, 770519, 727273, 686454, 647926,
    611561, 577237, 544839, 514260, 485396, 458153,
    432439, 408168, 385259, 363636, 343227, 323963,
    305781, 288618, 272419, 257130, 242698, 229077,
    216219, 204084, 192630, 181818, 171614, 161982,
    152890, 144309, 136210, 128565, 121349, 114538,
    108110, 102042, 96315, 90909, 85807, 80991,
    76445, 72155, 68105, 64282, 60675, 57269,
    54055, 51021, 48157, 45455, 42903, 40495,
    38223, 36077, 34052, 32141, 30337, 28635,
    27027, 25511, 24079, 22727, 21452, 20248,
    19111, 18039, 17026, 16071, 15169, 14317,
    13514, 12755, 12039, 11364, 10726, 10124,
    9556, 9019, 8513, 8035, 7584, 7159,
    6757, 6378, 6020, 5682, 5363, 5062
  };

  // Closeness pattern each harmonic must show, bit d for the count d back
  localparam logic [4:0] CLOSE_PATTERN [4] = '{5'b11111, 5'b10101, 5'b01001, 5'b10001};

  typedef struct packed {
    logic [25:0] period_sum;
    logic [6:0]  note_index;
    logic [3:0]  note_in_octave;
    logic [1:0]  harmonic_found;
  } note_result_t;

  typedef struct packed {
    logic [23:0]  count;
    bit           typed;   // expectation given in the row itself
    bit           hit;
    note_result_t res;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 26;
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    // zero count on a cleared ring: everything matches, nearest is the top note
    '{24'd0,        1'b1, 1'b1, '{26'd0, 7'd95, 4'd11, 2'd0}},
    // full-scale count against zeros: no pattern fits
    '{24'hFFFFFF,   1'b1, 1'b0, '0},
    '{24'hFFFFFF,   1'b0, 1'b0, '0},
    '{24'hFFFFFF,   1'b0, 1'b0, '0},
    '{24'hFFFFFF,   1'b0, 1'b0, '0},
    // ring full of maxima: fundamental, nearest is the bottom note
    '{24'hFFFFFF,   1'b1, 1'b1, '{26'd16777215, 7'd0, 4'd0, 2'd0}},
    '{24'd5851,     1'b0, 1'b0, '0},
    '{24'd5851,     1'b0, 1'b0, '0},
    '{24'd5851,     1'b0, 1'b0, '0},
    '{24'd5851,     1'b0, 1'b0, '0},
    // equidistant from two table entries: the lower index wins
    '{24'd5851,     1'b1, 1'b1, '{26'd5851, 7'd92, 4'd8, 2'd0}},
    // alternating pair: second harmonic pattern
    '{24'd10000,    1'b0, 1'b0, '0},
    '{24'd4000,     1'b0, 1'b0, '0},
    '{24'd10000,    1'b0, 1'b0, '0},
    '{24'd4000,     1'b0, 1'b0, '0},
    '{24'd10000,    1'b0, 1'b0, '0},
    // period of three counts
    '{24'd20000,    1'b0, 1'b0, '0},
    '{24'd10000,    1'b0, 1'b0, '0},
    '{24'd3000,     1'b0, 1'b0, '0},
    '{24'd6000,     1'b0, 1'b0, '0},
    '{24'd10000,    1'b0, 1'b0, '0},
    // period of four counts
    '{24'd10000,    1'b0, 1'b0, '0},
    '{24'd3000,     1'b0, 1'b0, '0},
    '{24'd5000,     1'b0, 1'b0, '0},
    '{24'd7000,     1'b0, 1'b0, '0},
    '{24'd10000,    1'b0, 1'b0, '0}
  };

  localparam int         PHASE_TOL  [PHASES] = '{0, 15, 7, 3, 10, 15, 0, 5};
  localparam idle_mode_t PHASE_IDLE [PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER,
                                                 IDLE_BOTH, IDLE_NONE, IDLE_SENDER,
                                                 IDLE_RECEIVER, IDLE_BOTH};

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [pnd_pkg::IN_DATA_W-1:0]  in_tdata = '0;   // [23:0] capture_count
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  // [25:0] period_sum, [32:26] note_index, [36:33] note_in_octave, [38:37] harmonic_found
  logic [pnd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_psel = 1'b0;
  logic                           cfg_penable = 1'b0;
  logic                           cfg_pwrite = 1'b0;
  logic [pnd_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [pnd_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [pnd_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  // Shadow of the block's state
  logic [23:0] count_ring [5];
  int          ring_ptr;
  logic [3:0]  tol_shift;

  note_result_t expected_notes [$];
  int fail_count    = 0;
  int send_pct      = 0;
  int recv_pct      = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  period_note_detector u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic flag_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  function automatic longint tick_gap(input longint a, input longint b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Store one count, then look for the first harmonic whose pattern fits and pick its nearest note
  function automatic bit detect_note(input logic [23:0] count, output note_result_t res);
    longint sums [5];
    longint diffs [5];
    longint acc;
    longint tol;
    longint best_dist;
    longint gap;
    int slot;
    int best;
    logic [4:0] pattern;
    bit hit;
    count_ring[ring_ptr] = count;
    ring_ptr = (ring_ptr == 4) ? 0 : ring_ptr + 1;
    slot = ring_ptr;
    acc = 0;
    for (int a = 0; a < 5; a++) begin
      slot = (slot == 0) ? 4 : slot - 1;
      acc += count_ring[slot];
      sums[a] = acc;
      diffs[a] = tick_gap(sums[0], count_ring[slot]);
    end
    hit = 1'b0;
    res = '0;
    for (int h = 0; h < 4; h++) begin
      if (!hit) begin
        tol = sums[h] >> tol_shift;
        for (int d = 0; d < 5; d++) pattern[d] = (diffs[d] <= tol);
        if (pattern == CLOSE_PATTERN[h]) begin
          hit = 1'b1;
          best = 0;
          best_dist = tick_gap(sums[h], NOTE_TICKS[0]);
          for (int i = 1; i < pnd_pkg::NOTE_LIMIT; i++) begin
            gap = tick_gap(sums[h], NOTE_TICKS[i]);
            if (gap < best_dist) begin
              best_dist = gap;
              best = i;
            end
          end
          res.period_sum     = sums[h][25:0];
          res.note_index     = best[6:0];
          res.note_in_octave = 4'(best % 12);
          res.harmonic_found = 2'(h);
        end
      end
    end
    return hit;
  endfunction

  // Offer one count; called and returning just after a falling edge
  task automatic push_count(input logic [23:0] count, input bit typed, input bit typed_hit,
                            input note_result_t typed_res);
    note_result_t res;
    bit hit;
    while ($urandom_range(99) < send_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= count;
    do @(posedge clk); while (!in_tready);
    hit = detect_note(count, res);
    if (typed) begin
      hit = typed_hit;
      res = typed_res;
    end
    if (hit) expected_notes.push_back(res);
    @(negedge clk);
  endtask

  // Stop offering, wait for every result and then for a no-result item to finish
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (expected_notes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // One APB transfer: setup phase, access phase, then return to idle
  task automatic cfg_access(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= TOL_SHIFT_ADDR;
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_tolerance(input logic [3:0] value);
    logic [31:0] rd;
    settle_block();
    cfg_access(1'b1, {28'd0, value}, rd);
    tol_shift = value;
    cfg_access(1'b0, '0, rd);
    if (rd !== {28'd0, value})
      flag_failure($sformatf("tolerance read-back: expected %0d, got %0h", value, rd));
  endtask

  function automatic logic [23:0] pick_count();
    case ($urandom_range(9))
      0:       return 24'($urandom_range(255));
      1:       return 24'($urandom);
      default: return 24'($urandom_range(1400000, 4000));
    endcase
  endfunction

  // Small wobble that usually stays inside the match tolerance
  function automatic logic [23:0] wobble(input logic [23:0] base);
    int sh;
    longint jmax;
    longint v;
    sh = tol_shift;
    jmax = longint'(base) >> (sh + 3);
    if (jmax == 0 || $urandom_range(2) == 0) return base;
    v = $urandom_range(int'(jmax));
    v = $urandom_range(1) ? base + v : base - v;
    if (v < 0) v = 0;
    if (v > 24'hFFFFFF) v = 24'hFFFFFF;
    return v[23:0];
  endfunction

  // Mostly repeating motifs of one to four counts, with noise runs and broken runs
  task automatic run_phase(input int n_items);
    logic [23:0] motif [4];
    logic [23:0] v;
    int sent;
    int k;
    int run_len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) < 2) begin
        run_len = $urandom_range(6, 1);
        for (int i = 0; i < run_len; i++) begin
          push_count(24'($urandom), 1'b0, 1'b0, '0);
          sent++;
        end
      end else begin
        k = $urandom_range(4, 1);
        for (int i = 0; i < k; i++) motif[i] = pick_count();
        run_len = $urandom_range(12, 5);
        for (int i = 0; i < run_len; i++) begin
          if ($urandom_range(19) == 0) v = 24'($urandom);
          else v = wobble(motif[i % k]);
          push_count(v, 1'b0, 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  // Receiver side: ready at the falling edge, optionally held off for a long stretch
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left   = hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_requests != hold_served) begin
      hold_served = hold_served + 1;
      hold_left   = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_pct);
    end
  end

  // Result check on each output transfer
  always @(posedge clk) begin
    note_result_t got;
    note_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.period_sum     = out_tdata[25:0];
      got.note_index     = out_tdata[32:26];
      got.note_in_octave = out_tdata[36:33];
      got.harmonic_found = out_tdata[38:37];
      if (expected_notes.size() == 0) begin
        flag_failure($sformatf("unexpected result: sum %0d note %0d oct %0d harm %0d",
                               got.period_sum, got.note_index, got.note_in_octave,
                               got.harmonic_found));
      end else begin
        want = expected_notes.pop_front();
        if (got.period_sum !== want.period_sum || got.note_index !== want.note_index ||
            got.note_in_octave !== want.note_in_octave ||
            got.harmonic_found !== want.harmonic_found)
          flag_failure($sformatf({"result mismatch: expected sum %0d note %0d oct %0d harm %0d,",
                                  " got sum %0d note %0d oct %0d harm %0d"},
                                 want.period_sum, want.note_index, want.note_in_octave,
                                 want.harmonic_found, got.period_sum, got.note_index,
                                 got.note_in_octave, got.harmonic_found));
      end
    end
  end

  // Watchdog on cycles without any stream transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [31:0] rd;
    for (int i = 0; i < 5; i++) count_ring[i] = '0;
    ring_ptr  = 0;
    tol_shift = TOL_SHIFT_RESET;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset value of the tolerance register
    cfg_access(1'b0, '0, rd);
    if (rd !== {28'd0, TOL_SHIFT_RESET})
      flag_failure($sformatf("tolerance after reset: expected %0d, got %0h",
                             TOL_SHIFT_RESET, rd));

    // Directed rows at the reset tolerance, no idling
    for (int r = 0; r < DIRECTED_ROWS; r++)
      push_count(DIRECTED[r].count, DIRECTED[r].typed, DIRECTED[r].hit, DIRECTED[r].res);

    // Random phases, each with its own tolerance and idling
    for (int p = 0; p < PHASES; p++) begin
      set_tolerance(4'(PHASE_TOL[p]));
      case (PHASE_IDLE[p])
        IDLE_NONE:     begin send_pct = 0;  recv_pct = 0;  end
        IDLE_SENDER:   begin send_pct = 63; recv_pct = 0;  end
        IDLE_RECEIVER: begin send_pct = 0;  recv_pct = 63; end
        default:       begin send_pct = 14; recv_pct = 14; end
      endcase
      // one phase runs into a long receiver hold-off so the block backs up
      if (p == 4) hold_requests = hold_requests + 1;
      run_phase(PHASE_ITEMS);
    end

    settle_block();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
